FILE: src/tln_pkg.sv
// Package for the text line normaliser: command word passed from the front
// end to the back end, opcodes, character codes and the ring-address helper.
// No dependencies.
`default_nettype none

package tln_pkg;

    // Capacity range of the line store; the command fields are sized for the top end.
    localparam int LINE_CAP_MAX     = 64;
    localparam int LINE_CAP_DEF     = 40;
    localparam int PTR_W            = $clog2(LINE_CAP_MAX);
    localparam int LEN_W            = $clog2(LINE_CAP_MAX + 1);

    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    // Opcodes carried on the input tuser.
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_EOL       = 8'h9B;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_PRINT_MAX = 8'd126;
    localparam logic [7:0] CH_PRINT_MIN = 8'd32;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_NONE      = 8'h00;

    // Segment kinds.
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_BREAK = 1'b1;

    // One unit of work for the back end: an optional segment read-out followed
    // by an optional store write.
    typedef struct packed {
        logic             emit;
        logic             kind;
        logic [PTR_W-1:0] start;
        logic [LEN_W-1:0] count;
        logic             wr;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
    } tln_cmd_t;

    // Ring address a + b, where a < cap and b <= cap.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [LEN_W-1:0] b,
                                                  input logic [LEN_W-1:0] cap);
        logic [LEN_W:0] sum;
        sum = {{(LEN_W + 1 - PTR_W){1'b0}}, a} + {1'b0, b};
        if (sum >= {1'b0, cap}) begin
            sum = sum - {1'b0, cap};
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/tln_front.sv
// Front end of the text line normaliser: accepts words, sanitises bytes and
// keeps the line bookkeeping, issuing at most one command per word. Uses tln_pkg.
`default_nettype none

module tln_front
    import tln_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic [1:0] s_tuser,
    input  wire logic       q_ready,
    output logic            q_push,
    output tln_cmd_t        q_cmd
);

    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] sp_reg, sp_next;
    logic [PTR_W-1:0] base_reg, base_next;
    logic             skip_lf_reg, skip_lf_next;
    logic             hi_fold_reg, hi_fold_next;

    logic             accept;
    logic             is_end;
    logic             is_high;
    logic [7:0]       ch;
    logic [LEN_W-1:0] kept_len;

    assign s_tready = q_ready;
    assign accept   = s_tvalid & q_ready;
    assign is_end   = (s_tdata == CH_EOL) || (s_tdata == CH_CR) || (s_tdata == CH_LF);
    assign is_high  = s_tdata > CH_PRINT_MAX;

    always_comb begin
        if (is_high) begin
            ch = CH_QMARK;
        end else if (s_tdata < CH_PRINT_MIN) begin
            ch = CH_SPACE;
        end else begin
            ch = s_tdata;
        end
    end

    always_comb begin
        len_next      = len_reg;
        sp_next       = sp_reg;
        base_next     = base_reg;
        skip_lf_next  = skip_lf_reg;
        hi_fold_next  = hi_fold_reg;
        kept_len      = len_reg;
        q_push        = 1'b0;
        q_cmd.emit    = 1'b0;
        q_cmd.kind    = KIND_LINE;
        q_cmd.start   = base_reg;
        q_cmd.count   = len_reg;
        q_cmd.wr      = 1'b0;
        q_cmd.waddr   = wrap_add(base_reg, len_reg, CAP);
        q_cmd.wdata   = ch;
        if (accept) begin
            case (s_tuser)
                OP_RESET: begin
                    len_next      = '0;
                    sp_next       = '0;
                    base_next     = '0;
                    skip_lf_next  = 1'b0;
                    hi_fold_next  = 1'b0;
                end
                OP_FINISH: begin
                    if (len_reg != '0) begin
                        q_push        = 1'b1;
                        q_cmd.emit    = 1'b1;
                        len_next      = '0;
                        sp_next       = '0;
                        hi_fold_next  = 1'b0;
                    end
                end
                OP_DATA: begin
                    skip_lf_next = 1'b0;
                    if (skip_lf_reg && (s_tdata == CH_LF)) begin
                        // Second half of a CR LF pair: dropped.
                    end else if (is_end) begin
                        skip_lf_next  = (s_tdata == CH_CR);
                        q_push        = 1'b1;
                        q_cmd.emit    = 1'b1;
                        len_next      = '0;
                        sp_next       = '0;
                        hi_fold_next  = 1'b0;
                    end else if (is_high && hi_fold_reg) begin
                        // Later bytes of a high run fold into the one '?'.
                    end else begin
                        q_push        = 1'b1;
                        q_cmd.wr      = 1'b1;
                        hi_fold_next  = is_high;
                        if (len_reg >= CAP) begin
                            // Full store: break after the last space, or take
                            // the whole store when there is none. The new
                            // character lands in the slot just freed at base.
                            q_cmd.emit    = 1'b1;
                            q_cmd.kind    = KIND_BREAK;
                            hi_fold_next  = 1'b0;
                            if (sp_reg != '0) begin
                                q_cmd.count = sp_reg;
                                kept_len    = len_reg - sp_reg;
                                base_next   = wrap_add(base_reg, sp_reg, CAP);
                            end else begin
                                kept_len    = '0;
                            end
                        end
                        len_next = kept_len + LEN_W'(1);
                        if (ch == CH_SPACE) begin
                            sp_next = kept_len + LEN_W'(1);
                        end else if (len_reg >= CAP) begin
                            sp_next = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            sp_reg       <= '0;
            base_reg     <= '0;
            skip_lf_reg  <= 1'b0;
            hi_fold_reg  <= 1'b0;
        end else begin
            len_reg      <= len_next;
            sp_reg       <= sp_next;
            base_reg     <= base_next;
            skip_lf_reg  <= skip_lf_next;
            hi_fold_reg  <= hi_fold_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tln_queue.sv
// Small command queue between the front and back ends of the line normaliser.
// Uses tln_pkg for the command type and depth.
`default_nettype none

module tln_queue
    import tln_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire tln_cmd_t  push_cmd,
    output logic           ready,
    input  wire logic      pop,
    output logic           valid,
    output tln_cmd_t       head
);

    tln_cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;
    logic                do_push;
    logic                do_pop;

    assign ready   = fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign valid   = fill_reg != '0;
    assign head    = slot_reg[rptr_reg];
    assign do_push = push & ready;
    assign do_pop  = pop & valid;

    always_comb begin
        wptr_next = do_push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = do_pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tln_back.sv
// Back end of the text line normaliser: owns the line store, reads segments
// out through a registered output word and performs store writes. Uses tln_pkg.
`default_nettype none

module tln_back
    import tln_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    input  wire tln_cmd_t   q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic [1:0]      m_tuser
);

    localparam int               AW  = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_OUT  = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;

    logic [7:0]       mem [LINE_CAPACITY];

    logic [2:0]       state_reg, state_next;
    tln_cmd_t         cur_reg, cur_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]       rdata_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_has_reg;
    logic             out_last_reg;
    logic             out_kind_reg;

    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic             load;
    logic [7:0]       ld_byte;
    logic             ld_has;
    logic             ld_last;
    logic             out_free;
    logic             seg_end;

    assign out_free = !out_valid_reg || m_tready;
    assign seg_end  = (idx_reg + LEN_W'(1)) == cur_reg.count;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = wrap_add(cur_reg.start, idx_reg + LEN_W'(1), CAP);
        wr_en      = 1'b0;
        load       = 1'b0;
        ld_byte    = rdata_reg;
        ld_has     = 1'b1;
        ld_last    = seg_end;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    if (!q_head.emit) begin
                        state_next = S_WR;
                    end else if (q_head.count == '0) begin
                        state_next = S_MARK;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg.start;
                idx_next   = '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    load = 1'b1;
                    if (seg_end) begin
                        state_next = S_WR;
                    end else begin
                        // Fetch the next character while this one is shown.
                        rd_en    = 1'b1;
                        idx_next = idx_reg + LEN_W'(1);
                    end
                end
            end
            S_MARK: begin
                if (out_free) begin
                    load       = 1'b1;
                    ld_byte    = CH_NONE;
                    ld_has     = 1'b0;
                    ld_last    = 1'b1;
                    state_next = S_WR;
                end
            end
            S_WR: begin
                wr_en      = cur_reg.wr;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cur_reg.waddr[AW-1:0]] <= cur_reg.wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        if (load) begin
            out_byte_reg <= ld_byte;
            out_has_reg  <= ld_has;
            out_last_reg <= ld_last;
            out_kind_reg <= cur_reg.kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_kind_reg, out_has_reg};

endmodule

`default_nettype wire

FILE: src/text_line_normalizer.sv
// Top level of the text line normaliser: front end, command queue and back end.
// Depends on tln_pkg, tln_front, tln_queue and tln_back.
//
//  Channel  | Direction | Handshake          | Contents
//  ---------+-----------+--------------------+---------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata: data_byte; tuser: opcode
//  m_       | out       | m_tvalid/m_tready  | tdata: out_byte; tlast: segment_last;
//           |           |                    | tuser: has_byte, segment_kind
//
// The front end takes one word a cycle while the four-entry command queue has room.
// In the back end a stored character takes a dequeue and a store write; a segment of
// n characters a dequeue, the first read, one output word a cycle while m_ does not
// stall, and a retire; an empty-line marker a dequeue, the marker word and a retire.
// Reset (aresetn low at a clock edge) empties the queue and clears the line state;
// the store itself needs no clearing pass. A stall on m_ holds the output word and
// the back end, and input words keep flowing until the queue fills.
`default_nettype none

module text_line_normalizer
    import tln_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [1:0] s_tuser,   // [1:0] opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,
    output logic [1:0]      m_tuser    // [0] has_byte, [1] segment_kind
);

    logic     push;
    tln_cmd_t push_cmd;
    logic     q_ready;
    logic     q_valid;
    logic     q_pop;
    tln_cmd_t q_head;

    // Sanitising, CR LF folding and line bookkeeping; the front end knows where
    // every character sits in the ring, so it decides overflow breaks on its own.
    tln_front #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_ready (q_ready),
        .q_push  (push),
        .q_cmd   (push_cmd)
    );

    tln_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    // Line store and output; commands are carried out strictly in order, so a
    // segment read always sees every earlier write.
    tln_back #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire
